@@ src/phosphor_decay_bloom_render_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the phosphor screen renderer
// Same-cycle-implication and next-cycle-implication checks; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef PHOSPHOR_DECAY_BLOOM_RENDER_MACROS_SVH
`define PHOSPHOR_DECAY_BLOOM_RENDER_MACROS_SVH

`ifndef SYNTHESIS
// consequent holds in the same cycle as the antecedent
`define PDB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pdb check failed");
// consequent holds in the cycle after the antecedent
`define PDB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pdb check failed");
`else
`define PDB_ASSERT_NOW(label, clk, rst, ante, cons)
`define PDB_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ src/pdb_pkg.sv @@
// ----------------------------------------------------------------------------
// pdb_pkg
// Sizes, codes, types and the exponent table of the phosphor screen renderer.
// ----------------------------------------------------------------------------
`default_nettype none

package pdb_pkg;

   // screen and kernel geometry
   localparam int MAX_WIDTH       = 256;
   localparam int MAX_HEIGHT      = 256;
   localparam int KERNEL_DIAMETER = 7;

   localparam int  KERNEL_RADIUS = KERNEL_DIAMETER / 2;
   localparam int  TAP_COUNT     = KERNEL_DIAMETER * KERNEL_DIAMETER;
   localparam bit  DIRECT_TAP    = (KERNEL_DIAMETER == 0);
   localparam int  TAP_SLOTS     = DIRECT_TAP ? 1 : TAP_COUNT;
   localparam int  KRAM_AW       = (TAP_SLOTS > 1) ? $clog2(TAP_SLOTS) : 1;
   localparam int  KD_W          = (KERNEL_DIAMETER > 1) ? $clog2(KERNEL_DIAMETER) : 1;
   localparam int  STORE_DEPTH   = MAX_WIDTH * MAX_HEIGHT;
   localparam int  STORE_AW      = $clog2(STORE_DEPTH);

   // field widths
   localparam int SIZE_W      = 9;
   localparam int EFF_W       = 11;
   localparam int COORD_W     = 12;
   localparam int LEVEL_W     = 24;
   localparam int TIME_W      = 32;
   localparam int Q16_W       = 16;
   localparam int REFL_W      = 24;
   localparam int RGBA_W      = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;
   localparam int SCR_W       = LEVEL_W + TIME_W;
   localparam int ACC_W       = 32 + $clog2(TAP_SLOTS + 1);

   localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;
   localparam logic [16:0]        LOG2E_Q16 = 17'd94548;
   localparam logic [63:0]        STEP_Q32  = 64'd4283353945;

   typedef enum logic [1:0] {
      CMD_HIT    = 2'd0,
      CMD_KERNEL = 2'd1,
      CMD_RENDER = 2'd2,
      CMD_IGNORE = 2'd3
   } pdb_cmd_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_SCREEN_WIDTH  = 3'd0,
      REG_SCREEN_HEIGHT = 3'd1,
      REG_DECAY_RATE    = 3'd2,
      REG_BLOOM_GAIN    = 3'd3,
      REG_EMIT_RED      = 3'd4,
      REG_EMIT_GREEN    = 3'd5,
      REG_EMIT_BLUE     = 3'd6,
      REG_REFLECT_RGB   = 3'd7
   } pdb_reg_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_SAT,
      ST_OUT
   } pdb_state_type;

   // 2^(-i/256) in Q1.16, entry 0 is exactly one
   typedef logic [16:0] pdb_exp2_type [256];

   function automatic pdb_exp2_type build_exp2_table();
      pdb_exp2_type tab;
      logic [63:0]  p;
      logic [63:0]  q;
      p = STEP_Q32;
      tab[0] = 17'd65536;
      for (int i = 1; i < 256; i++) begin
         q = (p + 64'd32768) >> 16;
         tab[i] = q[16:0];
         p = (p * STEP_Q32 + 64'h8000_0000) >> 32;
      end
      return tab;
   endfunction

   localparam pdb_exp2_type EXP2_TABLE = build_exp2_table();

endpackage

`default_nettype wire

@@ src/pdb_if.sv @@
// ----------------------------------------------------------------------------
// pdb channel interfaces
// Request, response and register-write channels with valid/ready transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface pdb_req_if import pdb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        cmd;
   logic [7:0]        pixel_x;
   logic [7:0]        pixel_y;
   logic [TIME_W-1:0] time_now;
   logic [23:0]       hit_intensity;
   logic [7:0]        kernel_index;
   logic [15:0]       kernel_weight;

   modport source (output valid, cmd, pixel_x, pixel_y, time_now, hit_intensity,
                   kernel_index, kernel_weight, input ready);
   modport sink   (input valid, cmd, pixel_x, pixel_y, time_now, hit_intensity,
                   kernel_index, kernel_weight, output ready);
endinterface

interface pdb_rsp_if import pdb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [RGBA_W-1:0] pixel_rgba;

   modport source (output valid, pixel_rgba, input ready);
   modport sink   (input valid, pixel_rgba, output ready);
endinterface

interface pdb_csr_if import pdb_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ src/pdb_ram.sv @@
// ----------------------------------------------------------------------------
// pdb_ram
// Generic one-write one-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pdb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                    clock,
   input  wire logic                                    wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                        wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ src/phosphor_decay_bloom_render.sv @@
// ----------------------------------------------------------------------------
// phosphor_decay_bloom_render
// Phosphor screen store with exponential decay and a bloom convolution.
// ----------------------------------------------------------------------------
// Channels: req_ch carries hit, kernel-write and render commands; rsp_ch returns
// one RGBA word per render; csr_ch writes the eight setup registers and is
// always ready.
// Items are handled one at a time. A kernel write, an off-screen hit or an
// unknown command is absorbed in the transfer cycle. An on-screen hit goes
// through read, three decay stages, write back and drain. A render issues one
// tap read per cycle over the kernel window (49 taps here) and then drains a
// 6-stage decay/multiply-accumulate pipeline before the sum is saturated and
// mapped to an RGBA word; the screen RAM read port, one tap a cycle, sets the
// pace of the window walk.
// Reset: registers take their defaults and a clearing pass over every store
// address zeroes the screen store and the kernel weights; no request is taken
// until it ends, and register writes are accepted throughout.
// Stall: a result sits in the output register while the next item is taken;
// a later render waits in its last step until that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

`include "phosphor_decay_bloom_render_macros.svh"

module phosphor_decay_bloom_render import pdb_pkg::*; (
   input wire logic   clock,
   input wire logic   reset,
   pdb_csr_if.sink    csr_ch,
   pdb_req_if.sink    req_ch,
   pdb_rsp_if.source  rsp_ch
);

   // setup registers
   logic [SIZE_W-1:0] scr_width_ff, scr_height_ff;
   logic [Q16_W-1:0]  decay_rate_ff, bloom_gain_ff;
   logic [Q16_W-1:0]  emit_red_ff, emit_green_ff, emit_blue_ff;
   logic [REFL_W-1:0] reflect_ff;

   // control
   pdb_state_type          state_ff, state_in;
   logic [STORE_AW-1:0]    clr_ff;
   logic                   hit_mode_ff;
   logic [KD_W-1:0]        row_ff, col_ff;
   logic [KRAM_AW-1:0]     tap_ff;
   logic [7:0]             px_ff, py_ff;
   logic [TIME_W-1:0]      now_ff;
   logic [LEVEL_W-1:0]     hit_ff;
   logic [STORE_AW-1:0]    hit_addr_ff;
   logic [ACC_W-1:0]       acc_ff;
   logic [LEVEL_W-1:0]     level_ff;
   logic                   rsp_valid_ff;
   logic [RGBA_W-1:0]      rsp_data_ff;

   logic start_hit, start_render, kernel_write, issue_en, last_tap;
   logic load_rsp, load_level, pipe_busy;

   // pipeline
   logic                   p1_v_ff, p2_v_ff, p3_v_ff, p4_v_ff, p5_v_ff, p6_v_ff;
   logic [47:0]            p2_e_ff;
   logic [LEVEL_W-1:0]     p2_level_ff, p3_level_ff;
   logic [Q16_W-1:0]       p2_weight_ff, p3_weight_ff, p4_weight_ff;
   logic                   p3_zero_ff, p4_zero_ff;
   logic [21:0]            p3_k_ff;
   logic [5:0]             p4_n_ff;
   logic [40:0]            p4_prod_ff;
   logic [39:0]            p5_t_ff;
   logic [39:0]            p6_u_ff;

   // screen geometry and tap address
   logic [EFF_W-1:0]       eff_w, eff_h;
   logic signed [COORD_W-1:0] sx, sy;
   logic                   tap_on, req_on;
   logic [STORE_AW-1:0]    tap_addr;

   // memories
   logic                   scr_we;
   logic [STORE_AW-1:0]    scr_waddr;
   logic [SCR_W-1:0]       scr_wdata, scr_rdata;
   logic                   krn_we;
   logic [KRAM_AW-1:0]     krn_waddr;
   logic [Q16_W-1:0]       krn_wdata, krn_rdata;

   logic [LEVEL_W-1:0]     decayed;
   logic [LEVEL_W:0]       hit_sum;
   logic [LEVEL_W-1:0]     hit_level;
   logic [37:0]            k_prod;

   function automatic logic [7:0] chan_value(input logic [LEVEL_W-1:0] level,
                                             input logic [Q16_W-1:0] emit,
                                             input logic [7:0] refl);
      logic [39:0] prod;
      logic [16:0] sum;
      prod = level * emit;
      sum = 17'(prod[39:24]) + 17'(refl);
      return (sum > 17'd255) ? 8'd255 : sum[7:0];
   endfunction

   // register writes, always ready
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scr_width_ff  <= SIZE_W'(256);
         scr_height_ff <= SIZE_W'(256);
         decay_rate_ff <= 16'd256;
         bloom_gain_ff <= 16'd256;
         emit_red_ff   <= 16'd65280;
         emit_green_ff <= 16'd65280;
         emit_blue_ff  <= 16'd65280;
         reflect_ff    <= '0;
      end else if (csr_ch.valid) begin
         case (pdb_reg_type'(csr_ch.index))
            REG_SCREEN_WIDTH:  scr_width_ff  <= csr_ch.data[SIZE_W-1:0];
            REG_SCREEN_HEIGHT: scr_height_ff <= csr_ch.data[SIZE_W-1:0];
            REG_DECAY_RATE:    decay_rate_ff <= csr_ch.data[Q16_W-1:0];
            REG_BLOOM_GAIN:    bloom_gain_ff <= csr_ch.data[Q16_W-1:0];
            REG_EMIT_RED:      emit_red_ff   <= csr_ch.data[Q16_W-1:0];
            REG_EMIT_GREEN:    emit_green_ff <= csr_ch.data[Q16_W-1:0];
            REG_EMIT_BLUE:     emit_blue_ff  <= csr_ch.data[Q16_W-1:0];
            REG_REFLECT_RGB:   reflect_ff    <= csr_ch.data[REFL_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp the size registers to the store
   assign eff_w = (EFF_W'(scr_width_ff) > EFF_W'(MAX_WIDTH)) ? EFF_W'(MAX_WIDTH)
                                                            : EFF_W'(scr_width_ff);
   assign eff_h = (EFF_W'(scr_height_ff) > EFF_W'(MAX_HEIGHT)) ? EFF_W'(MAX_HEIGHT)
                                                              : EFF_W'(scr_height_ff);

   assign req_on = (EFF_W'(req_ch.pixel_x) < eff_w) && (EFF_W'(req_ch.pixel_y) < eff_h);

   // tap coordinates relative to the window center
   assign sx = $signed(COORD_W'(px_ff)) + $signed(COORD_W'(col_ff))
             - $signed(COORD_W'(KERNEL_RADIUS));
   assign sy = $signed(COORD_W'(py_ff)) + $signed(COORD_W'(row_ff))
             - $signed(COORD_W'(KERNEL_RADIUS));
   assign tap_on = (sx >= 0) && (sy >= 0)
                && (sx < $signed(COORD_W'(eff_w))) && (sy < $signed(COORD_W'(eff_h)));
   assign tap_addr = STORE_AW'(sy) * STORE_AW'(MAX_WIDTH) + STORE_AW'(sx);

   assign last_tap = hit_mode_ff || DIRECT_TAP
                  || ((row_ff == KD_W'(KERNEL_DIAMETER - 1))
                      && (col_ff == KD_W'(KERNEL_DIAMETER - 1)));

   assign pipe_busy = p1_v_ff || p2_v_ff || p3_v_ff || p4_v_ff || p5_v_ff || p6_v_ff;

   // sequencer: next state and strobes
   always_comb begin
      state_in     = state_ff;
      start_hit    = 1'b0;
      start_render = 1'b0;
      kernel_write = 1'b0;
      issue_en     = 1'b0;
      load_level   = 1'b0;
      load_rsp     = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == STORE_AW'(STORE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_ch.valid) begin
               case (pdb_cmd_type'(req_ch.cmd))
                  CMD_HIT: begin
                     if (req_on) begin
                        start_hit = 1'b1;
                        state_in  = ST_ISSUE;
                     end
                  end
                  CMD_KERNEL: begin
                     kernel_write = (32'(req_ch.kernel_index) < 32'(TAP_COUNT));
                  end
                  CMD_RENDER: begin
                     start_render = 1'b1;
                     state_in     = ST_ISSUE;
                  end
                  default: ;
               endcase
            end
         end
         ST_ISSUE: begin
            issue_en = 1'b1;
            if (last_tap) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!pipe_busy) begin
               state_in = hit_mode_ff ? ST_IDLE : ST_SAT;
            end
         end
         ST_SAT: begin
            load_level = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_ch.ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
      end
   end

   // latch the item and walk the window
   always_ff @(posedge clock) begin
      if (start_hit || start_render) begin
         hit_mode_ff <= start_hit;
         px_ff       <= req_ch.pixel_x;
         py_ff       <= req_ch.pixel_y;
         now_ff      <= req_ch.time_now;
         hit_ff      <= req_ch.hit_intensity;
         tap_ff      <= '0;
         if (start_hit || DIRECT_TAP) begin
            row_ff <= KD_W'(KERNEL_RADIUS);
            col_ff <= KD_W'(KERNEL_RADIUS);
         end else begin
            row_ff <= '0;
            col_ff <= '0;
         end
      end else if (issue_en) begin
         hit_addr_ff <= tap_addr;
         tap_ff      <= tap_ff + 1'b1;
         if (col_ff == KD_W'(KERNEL_DIAMETER - 1)) begin
            col_ff <= '0;
            row_ff <= row_ff + 1'b1;
         end else begin
            col_ff <= col_ff + 1'b1;
         end
      end
   end

   // screen store: level and last hit time in one word
   assign scr_we    = (state_ff == ST_CLEAR) || (p4_v_ff && hit_mode_ff);
   assign scr_waddr = (state_ff == ST_CLEAR) ? clr_ff : hit_addr_ff;
   assign scr_wdata = (state_ff == ST_CLEAR) ? '0 : {hit_level, now_ff};

   pdb_ram #(
      .WIDTH (SCR_W),
      .DEPTH (STORE_DEPTH)
   ) u_screen_ram (
      .clock   (clock),
      .wr_en   (scr_we),
      .wr_addr (scr_waddr),
      .wr_data (scr_wdata),
      .rd_addr (tap_addr),
      .rd_data (scr_rdata)
   );

   // kernel weights, cleared with the screen
   assign krn_we    = ((state_ff == ST_CLEAR) && (32'(clr_ff) < 32'(TAP_SLOTS)))
                   || kernel_write;
   assign krn_waddr = (state_ff == ST_CLEAR) ? clr_ff[KRAM_AW-1:0]
                                             : KRAM_AW'(req_ch.kernel_index);
   assign krn_wdata = (state_ff == ST_CLEAR) ? '0 : req_ch.kernel_weight;

   pdb_ram #(
      .WIDTH (Q16_W),
      .DEPTH (TAP_SLOTS)
   ) u_kernel_ram (
      .clock   (clock),
      .wr_en   (krn_we),
      .wr_addr (krn_waddr),
      .wr_data (krn_wdata),
      .rd_addr (tap_ff),
      .rd_data (krn_rdata)
   );

   // pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
         p2_v_ff <= 1'b0;
         p3_v_ff <= 1'b0;
         p4_v_ff <= 1'b0;
         p5_v_ff <= 1'b0;
         p6_v_ff <= 1'b0;
      end else begin
         p1_v_ff <= issue_en && tap_on;
         p2_v_ff <= p1_v_ff;
         p3_v_ff <= p2_v_ff;
         p4_v_ff <= p3_v_ff;
         p5_v_ff <= p4_v_ff;
         p6_v_ff <= p5_v_ff;
      end
   end

   assign k_prod = p2_e_ff[20:0] * LOG2E_Q16;

   // decay exponent, log2 scale, table multiply
   always_ff @(posedge clock) begin
      p2_e_ff      <= (now_ff - scr_rdata[TIME_W-1:0]) * decay_rate_ff;
      p2_level_ff  <= scr_rdata[SCR_W-1:TIME_W];
      p2_weight_ff <= krn_rdata;

      p3_zero_ff   <= |p2_e_ff[47:21];
      p3_k_ff      <= k_prod[37:16];
      p3_level_ff  <= p2_level_ff;
      p3_weight_ff <= p2_weight_ff;

      p4_zero_ff   <= p3_zero_ff;
      p4_n_ff      <= p3_k_ff[21:16];
      p4_prod_ff   <= p3_level_ff * EXP2_TABLE[p3_k_ff[15:8]];
      p4_weight_ff <= p3_weight_ff;
   end

   // integer part of the exponent as a right shift
   always_comb begin
      logic [40:0] shifted;
      shifted = p4_prod_ff >> (7'd16 + 7'(p4_n_ff));
      decayed = p4_zero_ff ? '0 : shifted[LEVEL_W-1:0];
   end

   assign hit_sum   = (LEVEL_W+1)'(decayed) + (LEVEL_W+1)'(hit_ff);
   assign hit_level = hit_sum[LEVEL_W] ? LEVEL_MAX : hit_sum[LEVEL_W-1:0];

   // weight, gain, accumulate
   always_ff @(posedge clock) begin
      if (DIRECT_TAP) begin
         p5_t_ff <= {decayed, 16'd0};
         p6_u_ff <= {p5_t_ff[39:16], 16'd0} >> 8;
      end else begin
         p5_t_ff <= decayed * p4_weight_ff;
         p6_u_ff <= p5_t_ff[39:16] * bloom_gain_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start_render) begin
         acc_ff <= '0;
      end else if (p6_v_ff && !hit_mode_ff) begin
         acc_ff <= acc_ff + ACC_W'(p6_u_ff[39:8]);
      end
   end

   // saturate the sum, then map to color
   always_ff @(posedge clock) begin
      if (load_level) begin
         level_ff <= (acc_ff > ACC_W'(LEVEL_MAX)) ? LEVEL_MAX : acc_ff[LEVEL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_data_ff <= {chan_value(level_ff, emit_red_ff, reflect_ff[23:16]),
                         chan_value(level_ff, emit_green_ff, reflect_ff[15:8]),
                         chan_value(level_ff, emit_blue_ff, reflect_ff[7:0]),
                         8'd255};
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.pixel_rgba = rsp_data_ff;

   // checks
   `PDB_ASSERT_NOW(a_idle_pipe_empty, clock, reset, state_ff == ST_IDLE, !pipe_busy)
   `PDB_ASSERT_NOW(a_screen_write_src, clock, reset, scr_we,
                   (state_ff == ST_CLEAR) || (p4_v_ff && hit_mode_ff))
   `PDB_ASSERT_NEXT(a_hit_single_issue, clock, reset,
                    (state_ff == ST_ISSUE) && hit_mode_ff, state_ff == ST_DRAIN)

endmodule

`default_nettype wire

@@ tb/pdb_screen_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phosphor screen checker
// Watches the register, request and response channels, keeps its own copy of
// the screen store, kernel weights and setup, predicts the RGBA word of every
// render and compares it with the word the block returns.
// ----------------------------------------------------------------------------
`default_nettype none

module pdb_screen_checker import pdb_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   pdb_csr_if        csr_ch,
   pdb_req_if        req_ch,
   pdb_rsp_if        rsp_ch,
   output int        fail_count,
   output int        renders_pending
);

   logic [23:0] level_mem [STORE_DEPTH];
   logic [31:0] stamp_mem [STORE_DEPTH];
   logic [15:0] weight_mem [TAP_SLOTS];
   logic [16:0] pow2_frac [256];

   logic [8:0]  width_q;
   logic [8:0]  height_q;
   logic [15:0] rate_q;
   logic [15:0] gain_q;
   logic [15:0] emit_r_q;
   logic [15:0] emit_g_q;
   logic [15:0] emit_b_q;
   logic [23:0] refl_q;

   logic [31:0] rgba_expected [$];

   // 2^(-i/256) in Q1.16 by repeated rounded multiplication
   initial begin
      logic [63:0] p;
      p = STEP_Q32;
      pow2_frac[0] = 17'd65536;
      for (int i = 1; i < 256; i++) begin
         pow2_frac[i] = 17'((p + 64'd32768) >> 16);
         p = (p * STEP_Q32 + 64'h8000_0000) >> 32;
      end
   end

   function automatic int unsigned active_width();
      return (width_q > MAX_WIDTH) ? MAX_WIDTH : width_q;
   endfunction

   function automatic int unsigned active_height();
      return (height_q > MAX_HEIGHT) ? MAX_HEIGHT : height_q;
   endfunction

   // decayed intensity of one store entry at time now
   function automatic logic [63:0] decayed_at(int unsigned idx, logic [31:0] now);
      logic [31:0] dt;
      logic [63:0] e;
      logic [63:0] k;
      logic [63:0] n;
      dt = now - stamp_mem[idx];
      e  = 64'(dt) * 64'(rate_q);
      if (e >= (64'd32 << 16)) return 64'd0;
      k = (e * 64'd94548) >> 16;
      n = k >> 16;
      return (64'(level_mem[idx]) * 64'(pow2_frac[k[15:8]])) >> (16 + n);
   endfunction

   function automatic logic [7:0] color_byte(logic [23:0] lvl, logic [15:0] gain,
                                             logic [7:0] refl);
      logic [63:0] v;
      v = ((64'(lvl) * 64'(gain)) >> 24) + 64'(refl);
      return (v > 64'd255) ? 8'd255 : v[7:0];
   endfunction

   // bloom sum over the window, then map to RGBA
   function automatic logic [31:0] render_rgba(int x, int y, logic [31:0] now);
      logic [63:0] sum;
      logic [63:0] t;
      logic [23:0] lvl;
      int          sx;
      int          sy;
      int          w;
      int          h;
      w = active_width();
      h = active_height();
      sum = 0;
      if (KERNEL_DIAMETER > 0) begin
         for (int r = 0; r < KERNEL_DIAMETER; r++) begin
            for (int c = 0; c < KERNEL_DIAMETER; c++) begin
               sx = x + c - KERNEL_RADIUS;
               sy = y + r - KERNEL_RADIUS;
               if (sx < 0 || sy < 0 || sx >= w || sy >= h) continue;
               t = (decayed_at(sy * MAX_WIDTH + sx, now)
                    * 64'(weight_mem[r * KERNEL_DIAMETER + c])) >> 16;
               sum += (t * 64'(gain_q)) >> 8;
            end
         end
      end else if (x < w && y < h) begin
         sum = decayed_at(y * MAX_WIDTH + x, now);
      end
      lvl = (sum > 64'(LEVEL_MAX)) ? LEVEL_MAX : sum[23:0];
      return {color_byte(lvl, emit_r_q, refl_q[23:16]),
              color_byte(lvl, emit_g_q, refl_q[15:8]),
              color_byte(lvl, emit_b_q, refl_q[7:0]), 8'd255};
   endfunction

   assign renders_pending = rgba_expected.size();

   always @(posedge clock) begin
      logic [63:0]  v;
      int unsigned  idx;
      logic [31:0]  got;
      if (reset) begin
         for (int i = 0; i < STORE_DEPTH; i++) begin
            level_mem[i] = '0;
            stamp_mem[i] = '0;
         end
         for (int i = 0; i < TAP_SLOTS; i++) weight_mem[i] = '0;
         width_q  = 9'd256;
         height_q = 9'd256;
         rate_q   = 16'd256;
         gain_q   = 16'd256;
         emit_r_q = 16'd65280;
         emit_g_q = 16'd65280;
         emit_b_q = 16'd65280;
         refl_q   = '0;
         rgba_expected.delete();
         fail_count = 0;
      end else begin
         // register transfer
         if (csr_ch.valid && csr_ch.ready) begin
            case (pdb_reg_type'(csr_ch.index))
               REG_SCREEN_WIDTH:  width_q  = csr_ch.data[8:0];
               REG_SCREEN_HEIGHT: height_q = csr_ch.data[8:0];
               REG_DECAY_RATE:    rate_q   = csr_ch.data[15:0];
               REG_BLOOM_GAIN:    gain_q   = csr_ch.data[15:0];
               REG_EMIT_RED:      emit_r_q = csr_ch.data[15:0];
               REG_EMIT_GREEN:    emit_g_q = csr_ch.data[15:0];
               REG_EMIT_BLUE:     emit_b_q = csr_ch.data[15:0];
               REG_REFLECT_RGB:   refl_q   = csr_ch.data[23:0];
               default: ;
            endcase
         end
         // request transfer: update the store or predict a pixel
         if (req_ch.valid && req_ch.ready) begin
            case (pdb_cmd_type'(req_ch.cmd))
               CMD_HIT: begin
                  if (req_ch.pixel_x < active_width() && req_ch.pixel_y < active_height())
                  begin
                     idx = req_ch.pixel_y * MAX_WIDTH + req_ch.pixel_x;
                     v = decayed_at(idx, req_ch.time_now) + 64'(req_ch.hit_intensity);
                     level_mem[idx] = (v > 64'(LEVEL_MAX)) ? LEVEL_MAX : v[23:0];
                     stamp_mem[idx] = req_ch.time_now;
                  end
               end
               CMD_KERNEL: begin
                  if (req_ch.kernel_index < TAP_COUNT)
                     weight_mem[req_ch.kernel_index] = req_ch.kernel_weight;
               end
               CMD_RENDER: begin
                  rgba_expected.push_back(render_rgba(req_ch.pixel_x, req_ch.pixel_y,
                                                      req_ch.time_now));
               end
               default: ;
            endcase
         end
         // response transfer
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.pixel_rgba;
            if (rgba_expected.size() == 0) begin
               $error("unexpected pixel_rgba transfer: actual %h", got);
               fail_count++;
            end else begin
               if (got !== rgba_expected[0]) begin
                  $error("pixel_rgba mismatch: expected %h actual %h",
                         rgba_expected[0], got);
                  fail_count++;
               end
               void'(rgba_expected.pop_front());
            end
         end
      end
   end

endmodule

`default_nettype wire

@@ tb/tb_phosphor_decay_bloom_render.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phosphor screen renderer testbench
// Drives hits, kernel writes, renders and unknown commands through several
// register setups, with random gaps on both channels and one long response
// stall; the checker predicts and compares every rendered pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_phosphor_decay_bloom_render;
   import pdb_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int SETTLE      = 80;

   logic clock;
   logic reset;
   int   cycle_count = 0;
   int   fail_count;
   int   renders_pending;
   int   rendered = 0;
   bit   stall_done;
   logic [31:0] tick;
   int   spot_x;
   int   spot_y;

   pdb_csr_if csr_ch ();
   pdb_req_if req_ch ();
   pdb_rsp_if rsp_ch ();

   phosphor_decay_bloom_render dut (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   pdb_screen_checker checker_0 (
      .clock           (clock),
      .reset           (reset),
      .csr_ch          (csr_ch),
      .req_ch          (req_ch),
      .rsp_ch          (rsp_ch),
      .fail_count      (fail_count),
      .renders_pending (renders_pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // most gaps short, a few long
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // response side: random stalls, one long hold-off to back up the block
   always @(posedge clock) begin
      if (rsp_ch.valid && rsp_ch.ready) rendered <= rendered + 1;
   end

   initial begin
      int g;
      rsp_ch.ready = 1'b0;
      stall_done   = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!stall_done && rendered >= 60) begin
            stall_done = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (600) @(posedge clock);
         end
         g = gap_len();
         if (g > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (g) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
      end
   end

   // offer one item and hold it until transfer; lower valid only before a gap
   task automatic send_item(pdb_cmd_type op, int x, int y, logic [31:0] t_now,
                            logic [23:0] hit, logic [7:0] kidx, logic [15:0] kw);
      int g;
      req_ch.valid         <= 1'b1;
      req_ch.cmd           <= op;
      req_ch.pixel_x       <= x[7:0];
      req_ch.pixel_y       <= y[7:0];
      req_ch.time_now      <= t_now;
      req_ch.hit_intensity <= hit;
      req_ch.kernel_index  <= kidx;
      req_ch.kernel_weight <= kw;
      do @(posedge clock); while (!req_ch.ready);
      g = gap_len();
      if (g > 0) begin
         req_ch.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic write_reg(pdb_reg_type idx, logic [23:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
   endtask

   // drain outstanding work, then load a full setup
   task automatic load_setup(logic [8:0] w, logic [8:0] h, logic [15:0] rate,
                             logic [15:0] gain, logic [15:0] er, logic [15:0] eg,
                             logic [15:0] eb, logic [23:0] refl);
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (renders_pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      write_reg(REG_SCREEN_WIDTH, 24'(w));
      write_reg(REG_SCREEN_HEIGHT, 24'(h));
      write_reg(REG_DECAY_RATE, 24'(rate));
      write_reg(REG_BLOOM_GAIN, 24'(gain));
      write_reg(REG_EMIT_RED, 24'(er));
      write_reg(REG_EMIT_GREEN, 24'(eg));
      write_reg(REG_EMIT_BLUE, 24'(eb));
      write_reg(REG_REFLECT_RGB, refl);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
      spot_x = $urandom_range(0, (w == 0) ? 0 : ((w > 256) ? 255 : w - 1));
      spot_y = $urandom_range(0, (h == 0) ? 0 : ((h > 256) ? 255 : h - 1));
   endtask

   // random traffic, mostly near one spot so that renders see recent hits
   task automatic random_items(int count);
      int r;
      int x;
      int y;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 80) tick = tick + $urandom_range(0, 3);
         else if (r < 95) tick = tick + $urandom_range(4, 300);
         else tick = tick + $urandom;
         if ($urandom_range(0, 4) == 0) begin
            x = $urandom_range(0, 255);
            y = $urandom_range(0, 255);
         end else begin
            x = (spot_x + $urandom_range(0, 8) - 4) & 255;
            y = (spot_y + $urandom_range(0, 8) - 4) & 255;
         end
         r = $urandom_range(0, 99);
         if (r < 40)
            send_item(CMD_HIT, x, y, tick, 24'($urandom), 8'($urandom), 16'($urandom));
         else if (r < 55)
            send_item(CMD_KERNEL, x, y, tick, 24'($urandom),
                      ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                  : 8'($urandom_range(0, TAP_COUNT - 1)),
                      16'($urandom));
         else if (r < 95)
            send_item(CMD_RENDER, x, y, tick, 24'($urandom), 8'($urandom), 16'($urandom));
         else
            send_item(CMD_IGNORE, x, y, tick, 24'($urandom), 8'($urandom), 16'($urandom));
      end
   endtask

   initial begin
      reset         = 1'b1;
      tick          = $urandom_range(0, 1 << 20);
      spot_x        = 3;
      spot_y        = 3;
      req_ch.valid  = 1'b0;
      req_ch.cmd    = CMD_IGNORE;
      req_ch.pixel_x = '0;
      req_ch.pixel_y = '0;
      req_ch.time_now = '0;
      req_ch.hit_intensity = '0;
      req_ch.kernel_index = '0;
      req_ch.kernel_weight = '0;
      csr_ch.valid  = 1'b0;
      csr_ch.index  = REG_SCREEN_WIDTH;
      csr_ch.data   = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: kernel extremes, saturating hits, corners, wrap, unknown op
      load_setup(9'd256, 9'd256, 16'd256, 16'd256, 16'd65280, 16'd65280, 16'd65280, 24'd0);
      send_item(CMD_KERNEL, 0, 0, tick, 0, 8'd0, 16'hFFFF);
      send_item(CMD_KERNEL, 0, 0, tick, 0, 8'd24, 16'h8000);
      send_item(CMD_KERNEL, 0, 0, tick, 0, 8'd48, 16'hFFFF);
      send_item(CMD_KERNEL, 0, 0, tick, 0, 8'd49, 16'h1234);
      send_item(CMD_KERNEL, 0, 0, tick, 0, 8'd255, 16'hFFFF);
      send_item(CMD_HIT, 0, 0, tick, 24'hFFFFFF, 0, 0);
      send_item(CMD_HIT, 0, 0, tick, 24'hFFFFFF, 0, 0);
      send_item(CMD_HIT, 3, 3, tick, 24'h010000, 0, 0);
      send_item(CMD_HIT, 255, 255, tick, 24'hFFFFFF, 0, 0);
      send_item(CMD_HIT, 255, 0, tick, 24'h000001, 0, 0);
      send_item(CMD_RENDER, 0, 0, tick, 0, 0, 0);
      send_item(CMD_RENDER, 3, 3, tick, 0, 0, 0);
      send_item(CMD_RENDER, 255, 255, tick, 0, 0, 0);
      send_item(CMD_RENDER, 255, 0, tick + 5, 0, 0, 0);
      send_item(CMD_IGNORE, 7, 7, tick, 24'hFFFFFF, 8'd3, 16'hFFFF);
      send_item(CMD_HIT, 3, 3, tick - 32'd10, 24'h020000, 0, 0);
      send_item(CMD_RENDER, 3, 3, tick, 0, 0, 0);
      send_item(CMD_RENDER, 0, 0, 32'hFFFF_FFFF, 0, 0, 0);
      tick = tick + 1;

      // small screen, fast decay, off-screen hits and renders
      load_setup(9'd12, 9'd10, 16'd4096, 16'd65535, 16'd65535, 16'd8000, 16'd300,
                 24'h102030);
      send_item(CMD_HIT, 12, 2, tick, 24'hFFFFFF, 0, 0);
      send_item(CMD_HIT, 2, 10, tick, 24'hFFFFFF, 0, 0);
      send_item(CMD_RENDER, 13, 11, tick, 0, 0, 0);
      random_items(130);

      // zero width: nothing on screen
      load_setup(9'd0, 9'd256, 16'd65535, 16'd1000, 16'd1, 16'd0, 16'd65535, 24'hFFFFFF);
      random_items(30);

      // oversize width, one row, no decay
      load_setup(9'd511, 9'd1, 16'd0, 16'd700, 16'd40000, 16'd20000, 16'd65535,
                 24'h00FF00);
      random_items(130);

      // one-column screen, slowest decay extreme, moderate gain
      load_setup(9'd1, 9'd511, 16'd1, 16'd3000, 16'd65280, 16'd5000, 16'd65535, 24'h0A0B0C);
      random_items(60);

      load_setup(9'd9, 9'd9, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535,
                 24'h000000);
      random_items(130);

      // time runs through the wrap point
      tick = 32'hFFFF_FF00;
      load_setup(9'd256, 9'd256, 16'd16, 16'd2000, 16'd30000, 16'd65535, 16'd12000,
                 24'h203040);
      random_items(150);

      load_setup(9'($urandom_range(1, 256)), 9'($urandom_range(1, 256)),
                 16'($urandom_range(0, 2000)), 16'($urandom), 16'($urandom),
                 16'($urandom), 16'($urandom), 24'($urandom));
      random_items(150);

      // wait for the last renders, then let the block settle
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (renders_pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
